@@ rtl/core/uer_pkg.sv @@
// Shared types and constants of the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned WIDTH_W = 20;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned DIST_W = 16;
  localparam int unsigned MINW_W = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCKS_PER_US = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd3;

  localparam logic [7:0] CLOCKS_PER_US_RST = 8'd100;
  localparam logic [7:0] TRIGGER_WIDTH_RST = 8'd10;
  localparam logic [9:0] TIMEOUT_MS_RST = 10'd60;
  localparam logic [8:0] MIN_DISTANCE_RST = 9'd2;

  localparam logic [WIDTH_W-1:0] US_PER_MS = 20'd1000;
  localparam logic [MINW_W-1:0] CM_DIVISOR = 15'd58;
  localparam logic [8:0] TRIG_LOW_US = 9'd2;
  localparam logic [WIDTH_W-1:0] ELAPSED_MAX = '1;

  // Floor division by 58 is exact for every 20-bit width with this reciprocal.
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W = 27;
  localparam logic [RECIP_W-1:0] DIV58_RECIP = 27'd74051161;
  localparam int unsigned PROD_W = WIDTH_W + RECIP_W;

  typedef struct packed {
    logic [7:0]         clocks_per_us;
    logic [7:0]         trigger_width_us;
    logic [WIDTH_W-1:0] limit_us;
    logic [MINW_W-1:0]  min_width_us;
  } cfg_t;

  typedef struct packed {
    logic               trigger;
    logic               busy;
    logic               done;
    logic               timed_out;
    logic [WIDTH_W-1:0] echo_width;
    logic [COUNT_W-1:0] starts;
    logic [COUNT_W-1:0] timeouts;
  } res_t;

endpackage

@@ rtl/core/uer_core.sv @@
// Measurement sequencer that updates the ranging state once per request.
module uer_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  uer_pkg::cfg_t   cfg_i,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  logic            start_i,
  input  logic            echo_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output uer_pkg::res_t   res_o
);

  typedef enum logic [2:0] {
    PhIdle,
    PhTrigLow,
    PhTrigHigh,
    PhWaitRise,
    PhWaitFall,
    PhDone,
    PhTimeout
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [7:0]                  pre_q, pre_d;
  logic [uer_pkg::WIDTH_W-1:0] elapsed_q, elapsed_d;
  logic [uer_pkg::WIDTH_W-1:0] rise_q, rise_d;
  logic [uer_pkg::WIDTH_W-1:0] width_q, width_d;
  logic                        prev_q, prev_d;
  logic [uer_pkg::COUNT_W-1:0] starts_q, starts_d;
  logic [uer_pkg::COUNT_W-1:0] touts_q, touts_d;
  logic                        valid_q;

  logic       upd;
  logic       busy_now;
  logic [7:0] period;
  logic [7:0] pre_next;
  logic       rise;
  logic       fall;

  function automatic logic is_busy(phase_e p);
    return (p == PhTrigLow) || (p == PhTrigHigh) || (p == PhWaitRise) || (p == PhWaitFall);
  endfunction

  assign req_ready_o = !valid_q || res_ready_i;
  assign upd = req_valid_i && req_ready_o;
  assign busy_now = is_busy(phase_q);
  assign period = (cfg_i.clocks_per_us == 8'd0) ? 8'd1 : cfg_i.clocks_per_us;
  assign pre_next = pre_q + 8'd1;
  assign rise = !prev_q && echo_i;
  assign fall = prev_q && !echo_i;

  always_comb begin
    phase_d = phase_q;
    pre_d = pre_q;
    elapsed_d = elapsed_q;
    rise_d = rise_q;
    width_d = width_q;
    prev_d = prev_q;
    starts_d = starts_q;
    touts_d = touts_q;
    if (upd) begin
      prev_d = echo_i;
      if (start_i && !busy_now) begin
        width_d = '0;
        rise_d = '0;
        elapsed_d = '0;
        pre_d = '0;
        starts_d = starts_q + 16'd1;
        phase_d = PhTrigLow;
      end else if (busy_now) begin
        if (pre_next >= period || pre_next == 8'd0) begin
          pre_d = '0;
          if (elapsed_q < uer_pkg::ELAPSED_MAX) begin
            elapsed_d = elapsed_q + 20'd1;
          end
        end else begin
          pre_d = pre_next;
        end
        if (phase_d == PhTrigLow && elapsed_d >= 20'(uer_pkg::TRIG_LOW_US)) begin
          phase_d = PhTrigHigh;
        end
        if (phase_d == PhTrigHigh) begin
          if (elapsed_d >= 20'(uer_pkg::TRIG_LOW_US + 9'(cfg_i.trigger_width_us))) begin
            phase_d = PhWaitRise;
          end
        end else if (phase_d == PhWaitRise) begin
          if (rise) begin
            rise_d = elapsed_d;
            phase_d = PhWaitFall;
          end
        end else if (phase_d == PhWaitFall) begin
          if (fall) begin
            width_d = elapsed_d - rise_q;
            phase_d = PhDone;
          end
        end
        if (is_busy(phase_d) && elapsed_d > cfg_i.limit_us) begin
          phase_d = PhTimeout;
          touts_d = touts_q + 16'd1;
          width_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pre_q <= '0;
      elapsed_q <= '0;
      rise_q <= '0;
      width_q <= '0;
      prev_q <= 1'b0;
      starts_q <= '0;
      touts_q <= '0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pre_q <= pre_d;
      elapsed_q <= elapsed_d;
      rise_q <= rise_d;
      width_q <= width_d;
      prev_q <= prev_d;
      starts_q <= starts_d;
      touts_q <= touts_d;
      if (req_ready_o) begin
        valid_q <= req_valid_i;
      end
    end
  end

  assign res_valid_o = valid_q;
  assign res_o.trigger = (phase_q == PhTrigHigh);
  assign res_o.busy = busy_now;
  assign res_o.done = (phase_q == PhDone);
  assign res_o.timed_out = (phase_q == PhTimeout);
  assign res_o.echo_width = width_q;
  assign res_o.starts = starts_q;
  assign res_o.timeouts = touts_q;

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd |=> $stable(phase_q) && $stable(elapsed_q) && $stable(starts_q))
    else $error("state changed without a request");

  a_start_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && start_i && !busy_now) |=> (starts_q == $past(starts_q) + 16'd1) &&
    (phase_q == PhTrigLow) && (width_q == '0))
    else $error("accepted start not taken");

  a_timeout_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> (touts_q == $past(touts_q)) || ((phase_q == PhTimeout) && (width_q == '0)))
    else $error("timeout count moved outside a timeout");

endmodule

@@ rtl/core/uer_range.sv @@
// Distance conversion and bounds check feeding the result register.
module uer_range (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  uer_pkg::cfg_t                cfg_i,
  input  logic                         res_valid_i,
  output logic                         res_ready_o,
  input  uer_pkg::res_t                res_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output uer_pkg::res_t                out_res_o,
  output logic [uer_pkg::DIST_W-1:0]   distance_o,
  output logic                         distance_valid_o
);

  logic                         out_valid_q;
  uer_pkg::res_t                res_q;
  logic [uer_pkg::DIST_W-1:0]   dist_q;
  logic                         dvalid_q;

  logic [uer_pkg::PROD_W-1:0]   prod;
  logic                         in_bounds;
  logic [uer_pkg::DIST_W-1:0]   dist_d;

  assign res_ready_o = !out_valid_q || out_ready_i;
  assign prod = uer_pkg::PROD_W'(res_i.echo_width) * uer_pkg::PROD_W'(uer_pkg::DIV58_RECIP);
  assign in_bounds = res_i.done &&
                     (res_i.echo_width >= uer_pkg::WIDTH_W'(cfg_i.min_width_us)) &&
                     (res_i.echo_width <= cfg_i.limit_us);
  assign dist_d = in_bounds ?
                  uer_pkg::DIST_W'(prod[uer_pkg::PROD_W-1:uer_pkg::RECIP_SHIFT]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
      dist_q <= dist_d;
      dvalid_q <= in_bounds;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o = res_q;
  assign distance_o = dist_q;
  assign distance_valid_o = dvalid_q;

  a_valid_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && dvalid_q) |-> res_q.done && !res_q.busy && !res_q.timed_out)
    else $error("distance valid outside the done phase");

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !dvalid_q) |-> (dist_q == '0))
    else $error("distance not zero while not valid");

endmodule

@@ rtl/core/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger top level with request register and configuration registers.
// A result passes the request register, sequencer registers and range result register.
// One request per cycle while out_ready_i is high; the sequencer updates once per request.
// The distance divider is a reciprocal multiply in the final result stage.
// Reset (asynchronous, active low) empties the stages, idles the sequencer and loads defaults.
module ultrasonic_echo_ranger (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            start_request_i,
  input  logic                            echo_level_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            trigger_out_o,
  output logic                            busy_res_o,
  output logic                            done_res_o,
  output logic                            timed_out_o,
  output logic [uer_pkg::WIDTH_W-1:0]     echo_width_us_o,
  output logic [uer_pkg::DIST_W-1:0]      range_cm_o,
  output logic                            distance_valid_o,
  output logic [uer_pkg::COUNT_W-1:0]     start_count_o,
  output logic [uer_pkg::COUNT_W-1:0]     timeout_count_o
);

  uer_pkg::cfg_t cfg_q;
  logic          req_valid_q;
  logic          start_q;
  logic          echo_q;
  logic          core_ready;
  logic          res_valid;
  logic          res_ready;
  uer_pkg::res_t res;
  uer_pkg::res_t out_res;

  assign in_ready_o = !req_valid_q || core_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clocks_per_us <= uer_pkg::CLOCKS_PER_US_RST;
      cfg_q.trigger_width_us <= uer_pkg::TRIGGER_WIDTH_RST;
      cfg_q.limit_us <= uer_pkg::WIDTH_W'(uer_pkg::TIMEOUT_MS_RST) * uer_pkg::US_PER_MS;
      cfg_q.min_width_us <= uer_pkg::MINW_W'(uer_pkg::MIN_DISTANCE_RST) * uer_pkg::CM_DIVISOR;
      req_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          uer_pkg::CFG_CLOCKS_PER_US: cfg_q.clocks_per_us <= cfg_wdata_i[7:0];
          uer_pkg::CFG_TRIGGER_WIDTH: cfg_q.trigger_width_us <= cfg_wdata_i[7:0];
          uer_pkg::CFG_TIMEOUT_MS:
            cfg_q.limit_us <= uer_pkg::WIDTH_W'(cfg_wdata_i) * uer_pkg::US_PER_MS;
          uer_pkg::CFG_MIN_DISTANCE:
            cfg_q.min_width_us <= uer_pkg::MINW_W'(cfg_wdata_i[8:0]) * uer_pkg::CM_DIVISOR;
          default: ;
        endcase
      end
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      start_q <= start_request_i;
      echo_q <= echo_level_i;
    end
  end

  uer_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (req_valid_q),
    .req_ready_o (core_ready),
    .start_i     (start_q),
    .echo_i      (echo_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  uer_range u_range (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .res_valid_i      (res_valid),
    .res_ready_o      (res_ready),
    .res_i            (res),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_res_o        (out_res),
    .distance_o       (range_cm_o),
    .distance_valid_o (distance_valid_o)
  );

  assign trigger_out_o = out_res.trigger;
  assign busy_res_o = out_res.busy;
  assign done_res_o = out_res.done;
  assign timed_out_o = out_res.timed_out;
  assign echo_width_us_o = out_res.echo_width;
  assign start_count_o = out_res.starts;
  assign timeout_count_o = out_res.timeouts;

endmodule
